/* rtl/tsb_pkg.sv */
// tsb_pkg: shared widths, constants and the item types that pass from the
// front part of the triangle setup block through the queue to the back part.
// No dependencies.
package tsb_pkg;

  localparam int unsigned CW        = 32;  // vertex coordinate, Q16.16
  localparam int unsigned CROSS_W   = 65;  // cross product magnitude
  localparam int unsigned LEN_W     = 7;   // bit length 0..65
  localparam int unsigned UNIT_BITS = 30;  // Q2.30 normal
  localparam int unsigned NORM_W    = 32;
  localparam int unsigned PLANE_W   = 48;

  localparam logic [10:0] XY_MAX   = 11'd2047;
  localparam logic [10:0] Z_MAX    = 11'd1023;
  localparam logic [31:0] MIN_BIAS = 32'h0000_0200;

  // what the back part carries along untouched
  typedef struct packed {
    logic [31:0]          box_min_code;
    logic [31:0]          box_max_code;
    logic [2:0]           edge_flat;
    logic signed [CW-1:0] vx1;
    logic signed [CW-1:0] vy1;
    logic signed [CW-1:0] vz1;
  } side_t;

  // one cross product component, sign and magnitude
  typedef struct packed {
    logic               neg;
    logic [CROSS_W-1:0] mag;
  } cross_t;

  typedef struct packed {
    side_t  side;
    cross_t wx;
    cross_t wy;
    cross_t wz;
  } mid_t;

endpackage

/* rtl/tsb_queue.sv */
// tsb_queue: short register queue that decouples the front and back parts.
// Depends on tsb_pkg for the item type.
module tsb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsb_pkg::mid_t wdata,
  output logic          full,
  input  logic          pop,
  output tsb_pkg::mid_t rdata,
  output logic          empty
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tsb_pkg::mid_t    mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/tsb_front.sv */
// tsb_front: configuration registers, bounding box quantization and packing,
// edge flags and the exact cross product. Four stages, one enable.
// Depends on tsb_pkg.
module tsb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [tsb_pkg::CW-1:0] vtx [9],
  output logic                         q_push,
  output tsb_pkg::mid_t                q_data,
  input  logic                         q_full
);

  typedef enum logic [2:0] {
    CFG_OFFSET_X = 3'd0,
    CFG_OFFSET_Y = 3'd1,
    CFG_OFFSET_Z = 3'd2,
    CFG_SCALE_X  = 3'd3,
    CFG_SCALE_Y  = 3'd4,
    CFG_SCALE_Z  = 3'd5
  } cfg_idx_t;

  logic signed [31:0] off_r [3];
  logic [31:0]        scl_r [3];

  logic               fe;
  logic               f1_valid_r, f2_valid_r, f3_valid_r, f4_valid_r;

  // stage 1: box corners and edge differences
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic signed [32:0] d_r [8];   // dx1 dy1 dz1 dx2 dy2 dz2 dx3 dy3
  logic signed [31:0] v1_f1_r [3];
  // stage 2: offset sums and difference magnitudes
  logic signed [32:0] sum_r [6]; // min x y z, max x y z
  logic [31:0]        mag_r [8];
  logic [7:0]         neg_r;
  logic signed [31:0] v1_f2_r [3];
  // stage 3: products
  logic [5:0]         pos_r;
  logic [63:0]        prod_r [6];
  logic [63:0]        cp_r [6];  // m1, m2 per cross component
  logic [2:0]         s1_r, s2_r;
  logic [2:0]         flat_r;
  logic signed [31:0] v1_f3_r [3];
  // stage 4
  tsb_pkg::mid_t      q_data_r;
  tsb_pkg::mid_t      mid_nxt;
  logic [10:0]        zq_lo, zq_hi;

  function automatic logic signed [31:0] min3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    logic signed [31:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [31:0] max3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    logic signed [31:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [10:0] clamp(input logic pos, input logic [63:0] p,
                                        input logic [10:0] maxv);
    logic [31:0] hi;
    hi = p[63:32];
    if (!pos) return 11'd0;
    return (hi > {21'd0, maxv}) ? maxv : hi[10:0];
  endfunction

  function automatic tsb_pkg::cross_t combine(input logic [63:0] m1,
                                              input logic [63:0] m2,
                                              input logic s1, input logic s2);
    tsb_pkg::cross_t r;
    if (s1 == s2) begin
      r.mag = {1'b0, m1} + {1'b0, m2};
      r.neg = s1;
    end else if (m1 >= m2) begin
      r.mag = {1'b0, m1 - m2};
      r.neg = s1;
    end else begin
      r.mag = {1'b0, m2 - m1};
      r.neg = s2;
    end
    return r;
  endfunction

  assign fe      = !(f4_valid_r && q_full);
  assign in_full = !fe;
  assign q_push  = f4_valid_r && !q_full;
  assign q_data  = q_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
      scl_r[0] <= 32'd65536;
      scl_r[1] <= 32'd65536;
      scl_r[2] <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_X: off_r[0] <= cfg_wdata;
        CFG_OFFSET_Y: off_r[1] <= cfg_wdata;
        CFG_OFFSET_Z: off_r[2] <= cfg_wdata;
        CFG_SCALE_X:  scl_r[0] <= cfg_wdata;
        CFG_SCALE_Y:  scl_r[1] <= cfg_wdata;
        CFG_SCALE_Z:  scl_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
      f4_valid_r <= 1'b0;
    end else if (fe) begin
      f1_valid_r <= in_push;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
      f4_valid_r <= f3_valid_r;
    end
  end

  always_comb begin
    zq_lo = clamp(pos_r[2], prod_r[2], tsb_pkg::Z_MAX);
    zq_hi = clamp(pos_r[5], prod_r[5], tsb_pkg::Z_MAX);
    mid_nxt.side.box_min_code = {clamp(pos_r[0], prod_r[0], tsb_pkg::XY_MAX),
                                 clamp(pos_r[1], prod_r[1], tsb_pkg::XY_MAX),
                                 zq_lo[9:0]} - tsb_pkg::MIN_BIAS;
    mid_nxt.side.box_max_code = {clamp(pos_r[3], prod_r[3], tsb_pkg::XY_MAX),
                                 clamp(pos_r[4], prod_r[4], tsb_pkg::XY_MAX),
                                 zq_hi[9:0]};
    mid_nxt.side.edge_flat = flat_r;
    mid_nxt.side.vx1       = v1_f3_r[0];
    mid_nxt.side.vy1       = v1_f3_r[1];
    mid_nxt.side.vz1       = v1_f3_r[2];
    mid_nxt.wx = combine(cp_r[0], cp_r[1], s1_r[0], s2_r[0]);
    mid_nxt.wy = combine(cp_r[2], cp_r[3], s1_r[1], s2_r[1]);
    mid_nxt.wz = combine(cp_r[4], cp_r[5], s1_r[2], s2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a]    <= min3(vtx[a], vtx[a+3], vtx[a+6]);
        hi_r[a]    <= max3(vtx[a], vtx[a+3], vtx[a+6]);
        v1_f1_r[a] <= vtx[a];
        d_r[a]     <= {vtx[a+3][31], vtx[a+3]} - {vtx[a][31], vtx[a]};
        d_r[a+3]   <= {vtx[a+6][31], vtx[a+6]} - {vtx[a+3][31], vtx[a+3]};
      end
      d_r[6] <= {vtx[0][31], vtx[0]} - {vtx[6][31], vtx[6]};
      d_r[7] <= {vtx[1][31], vtx[1]} - {vtx[7][31], vtx[7]};

      for (int a = 0; a < 3; a++) begin
        sum_r[a]   <= {lo_r[a][31], lo_r[a]} + {off_r[a][31], off_r[a]};
        sum_r[a+3] <= {hi_r[a][31], hi_r[a]} + {off_r[a][31], off_r[a]};
        v1_f2_r[a] <= v1_f1_r[a];
      end
      for (int i = 0; i < 8; i++) begin
        mag_r[i] <= d_r[i][32] ? 32'(-d_r[i]) : d_r[i][31:0];
        neg_r[i] <= d_r[i][32];
      end

      for (int i = 0; i < 6; i++) begin
        pos_r[i]  <= !sum_r[i][32] && (sum_r[i] != '0);
        prod_r[i] <= 64'(sum_r[i][31:0]) * 64'(scl_r[i % 3]);
      end
      cp_r[0] <= 64'(mag_r[1]) * 64'(mag_r[5]);
      cp_r[1] <= 64'(mag_r[4]) * 64'(mag_r[2]);
      cp_r[2] <= 64'(mag_r[2]) * 64'(mag_r[3]);
      cp_r[3] <= 64'(mag_r[5]) * 64'(mag_r[0]);
      cp_r[4] <= 64'(mag_r[0]) * 64'(mag_r[4]);
      cp_r[5] <= 64'(mag_r[3]) * 64'(mag_r[1]);
      s1_r    <= {neg_r[0] ^ neg_r[4], neg_r[2] ^ neg_r[3], neg_r[1] ^ neg_r[5]};
      s2_r    <= {!(neg_r[3] ^ neg_r[1]), !(neg_r[5] ^ neg_r[0]),
                  !(neg_r[4] ^ neg_r[2])};
      flat_r  <= {mag_r[6] > mag_r[7], mag_r[3] > mag_r[4], mag_r[0] > mag_r[1]};
      for (int a = 0; a < 3; a++) begin
        v1_f3_r[a] <= v1_f2_r[a];
      end

      q_data_r <= mid_nxt;
    end
  end

endmodule

/* rtl/tsb_back.sv */
// tsb_back: normalizes the cross product, takes the integer square root and
// divides each component by it, then forms the plane offset. Fully pipelined
// with one enable that the output register controls. Depends on tsb_pkg.
module tsb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsb_pkg::mid_t                       q_data,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic [31:0]                         out_box_min_code,
  output logic [31:0]                         out_box_max_code,
  output logic signed [tsb_pkg::NORM_W-1:0]   out_normal_a,
  output logic signed [tsb_pkg::NORM_W-1:0]   out_normal_b,
  output logic signed [tsb_pkg::NORM_W-1:0]   out_normal_c,
  output logic signed [tsb_pkg::PLANE_W-1:0]  out_plane_offset,
  output logic                                out_edge1_flat,
  output logic                                out_edge2_flat,
  output logic                                out_edge3_flat
);

  localparam int unsigned CH_W   = 8;
  localparam int unsigned CH_N   = (tsb_pkg::CROSS_W + CH_W - 1) / CH_W;
  localparam int unsigned PAD_W  = CH_N * CH_W;
  localparam int unsigned CL_W   = $clog2(CH_W + 1);
  localparam int unsigned RM_W   = tsb_pkg::UNIT_BITS;
  localparam int unsigned SQ2_W  = 2 * RM_W;
  localparam int unsigned SQ_W   = 63;
  localparam int unsigned SQ_N   = 32;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned DV_N   = ROOT_W;

  typedef struct packed {
    tsb_pkg::side_t           side;
    logic                     deg;
    logic [2:0]               neg;
    logic [2:0][RM_W-1:0]     m;
  } carry_t;

  logic be;

  // stage 1, chunked leading one search
  logic                     b1_vld_r;
  tsb_pkg::side_t           b1_side_r;
  tsb_pkg::cross_t          b1_w_r [3];
  logic [CL_W-1:0]          b1_cl_r [CH_N];
  logic [CL_W-1:0]          cl_nxt [CH_N];
  logic [PAD_W-1:0]         w_pad;
  // stage 2, bit length
  logic                     b2_vld_r;
  tsb_pkg::side_t           b2_side_r;
  tsb_pkg::cross_t          b2_w_r [3];
  logic [tsb_pkg::LEN_W-1:0] b2_len_r, len_nxt;
  // stage 3, scaled components
  logic                     b3_vld_r;
  carry_t                   b3_c_r, b3_c_nxt;
  logic [tsb_pkg::CROSS_W-1:0] sh_t [3];
  // stages 4, 5, sum of squares
  logic                     b4_vld_r, b5_vld_r;
  carry_t                   b4_c_r, b5_c_r;
  logic [SQ2_W-1:0]         b4_sq_r [3];
  logic [SQ_W-1:0]          b5_ss_r;
  // square root, one result bit a stage
  logic                     sq_vld_r [SQ_N];
  carry_t                   sq_c_r [SQ_N];
  logic [SQ_W-1:0]          sq_v_r [SQ_N], sq_r_r [SQ_N];
  logic [SQ_W-1:0]          sq_v_in [SQ_N], sq_r_in [SQ_N];
  logic [SQ_W-1:0]          sq_v_nxt [SQ_N], sq_r_nxt [SQ_N];
  logic [SQ_W-1:0]          bitv, rb;
  // restoring divide, one quotient bit a stage, three lanes
  logic                     dv_vld_r [DV_N];
  carry_t                   dv_c_r [DV_N];
  logic [ROOT_W-1:0]        dv_n_r [DV_N];
  logic [ROOT_W-1:0]        dv_rem_r [DV_N][3], dv_q_r [DV_N][3];
  logic [ROOT_W-1:0]        dv_rem_in [DV_N][3], dv_q_in [DV_N][3];
  logic [ROOT_W-1:0]        dv_rem_nxt [DV_N][3], dv_q_nxt [DV_N][3];
  logic [ROOT_W-1:0]        dv_n_in [DV_N];
  logic [ROOT_W:0]          tmp;
  // plane offset
  logic                     p1_vld_r, p2_vld_r, p3_vld_r;
  tsb_pkg::side_t           p1_side_r, p2_side_r, p3_side_r;
  logic signed [31:0]       p1_nrm_r [3], p2_nrm_r [3], p3_nrm_r [3];
  logic signed [31:0]       nrm_nxt [3];
  logic signed [63:0]       p2_prod_r [3];
  logic signed [63:0]       p3_sum_r;
  logic [63:0]              d_mag;
  logic [tsb_pkg::PLANE_W-1:0] dq_nxt;
  // output register
  logic                     o_vld_r;
  tsb_pkg::side_t           o_side_r;
  logic signed [31:0]       o_nrm_r [3];
  logic signed [tsb_pkg::PLANE_W-1:0] o_plane_r;

  assign be        = !o_vld_r || out_pop;
  assign q_pop     = be && !q_empty;
  assign out_empty = !o_vld_r;

  assign out_box_min_code = o_side_r.box_min_code;
  assign out_box_max_code = o_side_r.box_max_code;
  assign out_edge1_flat   = o_side_r.edge_flat[0];
  assign out_edge2_flat   = o_side_r.edge_flat[1];
  assign out_edge3_flat   = o_side_r.edge_flat[2];
  assign out_normal_a     = o_nrm_r[0];
  assign out_normal_b     = o_nrm_r[1];
  assign out_normal_c     = o_nrm_r[2];
  assign out_plane_offset = o_plane_r;

  always_comb begin
    w_pad = PAD_W'(q_data.wx.mag | q_data.wy.mag | q_data.wz.mag);
    for (int i = 0; i < CH_N; i++) begin
      cl_nxt[i] = '0;
      for (int j = 0; j < CH_W; j++) begin
        if (w_pad[i*CH_W + j]) cl_nxt[i] = CL_W'(j + 1);
      end
    end
  end

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < CH_N; i++) begin
      if (b1_cl_r[i] != '0) begin
        len_nxt = tsb_pkg::LEN_W'(i * CH_W) + tsb_pkg::LEN_W'(b1_cl_r[i]);
      end
    end
  end

  // scale so the largest magnitude lands in [2^29, 2^30)
  always_comb begin
    b3_c_nxt.side = b2_side_r;
    b3_c_nxt.deg  = (b2_len_r == '0);
    for (int a = 0; a < 3; a++) begin
      if (b2_len_r > tsb_pkg::LEN_W'(RM_W)) begin
        sh_t[a] = b2_w_r[a].mag >> (b2_len_r - tsb_pkg::LEN_W'(RM_W));
      end else begin
        sh_t[a] = b2_w_r[a].mag << (tsb_pkg::LEN_W'(RM_W) - b2_len_r);
      end
      b3_c_nxt.m[a]   = sh_t[a][RM_W-1:0];
      b3_c_nxt.neg[a] = b2_w_r[a].neg;
    end
  end

  always_comb begin
    sq_v_in[0] = b5_ss_r;
    sq_r_in[0] = '0;
    for (int k = 1; k < SQ_N; k++) begin
      sq_v_in[k] = sq_v_r[k-1];
      sq_r_in[k] = sq_r_r[k-1];
    end
    bitv = '0;
    rb   = '0;
    for (int k = 0; k < SQ_N; k++) begin
      bitv = SQ_W'(1) << (2 * (SQ_N - 1 - k));
      rb   = sq_r_in[k] + bitv;
      if (sq_v_in[k] >= rb) begin
        sq_v_nxt[k] = sq_v_in[k] - rb;
        sq_r_nxt[k] = (sq_r_in[k] >> 1) + bitv;
      end else begin
        sq_v_nxt[k] = sq_v_in[k];
        sq_r_nxt[k] = sq_r_in[k] >> 1;
      end
    end
  end

  always_comb begin
    dv_n_in[0] = sq_r_r[SQ_N-1][ROOT_W-1:0];
    for (int a = 0; a < 3; a++) begin
      dv_rem_in[0][a] = ROOT_W'(sq_c_r[SQ_N-1].m[a]);
      dv_q_in[0][a]   = '0;
    end
    for (int j = 1; j < DV_N; j++) begin
      dv_n_in[j] = dv_n_r[j-1];
      for (int a = 0; a < 3; a++) begin
        dv_rem_in[j][a] = dv_rem_r[j-1][a];
        dv_q_in[j][a]   = dv_q_r[j-1][a];
      end
    end
    tmp = '0;
    for (int j = 0; j < DV_N; j++) begin
      for (int a = 0; a < 3; a++) begin
        // first step sees the bare magnitude, later ones shift in a zero
        tmp = (j == 0) ? {1'b0, dv_rem_in[j][a]} : {dv_rem_in[j][a], 1'b0};
        if (tmp >= {1'b0, dv_n_in[j]}) begin
          tmp = tmp - {1'b0, dv_n_in[j]};
          dv_q_nxt[j][a] = {dv_q_in[j][a][ROOT_W-2:0], 1'b1};
        end else begin
          dv_q_nxt[j][a] = {dv_q_in[j][a][ROOT_W-2:0], 1'b0};
        end
        dv_rem_nxt[j][a] = tmp[ROOT_W-1:0];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dv_c_r[DV_N-1].deg) begin
        nrm_nxt[a] = '0;
      end else if (dv_c_r[DV_N-1].neg[a]) begin
        nrm_nxt[a] = -$signed({1'b0, dv_q_r[DV_N-1][a]});
      end else begin
        nrm_nxt[a] = $signed({1'b0, dv_q_r[DV_N-1][a]});
      end
    end
  end

  // truncate toward zero
  always_comb begin
    d_mag = p3_sum_r[63] ? 64'(-p3_sum_r) : 64'(p3_sum_r);
    if (p3_sum_r[63]) begin
      dq_nxt = -(tsb_pkg::PLANE_W'(d_mag >> tsb_pkg::UNIT_BITS));
    end else begin
      dq_nxt = tsb_pkg::PLANE_W'(d_mag >> tsb_pkg::UNIT_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
      b4_vld_r <= 1'b0;
      b5_vld_r <= 1'b0;
      for (int k = 0; k < SQ_N; k++) sq_vld_r[k] <= 1'b0;
      for (int j = 0; j < DV_N; j++) dv_vld_r[j] <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (be) begin
      b1_vld_r    <= !q_empty;
      b2_vld_r    <= b1_vld_r;
      b3_vld_r    <= b2_vld_r;
      b4_vld_r    <= b3_vld_r;
      b5_vld_r    <= b4_vld_r;
      sq_vld_r[0] <= b5_vld_r;
      for (int k = 1; k < SQ_N; k++) sq_vld_r[k] <= sq_vld_r[k-1];
      dv_vld_r[0] <= sq_vld_r[SQ_N-1];
      for (int j = 1; j < DV_N; j++) dv_vld_r[j] <= dv_vld_r[j-1];
      p1_vld_r <= dv_vld_r[DV_N-1];
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      o_vld_r  <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b1_side_r <= q_data.side;
      b1_w_r[0] <= q_data.wx;
      b1_w_r[1] <= q_data.wy;
      b1_w_r[2] <= q_data.wz;
      for (int i = 0; i < CH_N; i++) b1_cl_r[i] <= cl_nxt[i];

      b2_side_r <= b1_side_r;
      b2_len_r  <= len_nxt;
      for (int a = 0; a < 3; a++) b2_w_r[a] <= b1_w_r[a];

      b3_c_r <= b3_c_nxt;

      b4_c_r <= b3_c_r;
      for (int a = 0; a < 3; a++) begin
        b4_sq_r[a] <= SQ2_W'(b3_c_r.m[a]) * SQ2_W'(b3_c_r.m[a]);
      end

      b5_c_r  <= b4_c_r;
      b5_ss_r <= SQ_W'(b4_sq_r[0]) + SQ_W'(b4_sq_r[1]) + SQ_W'(b4_sq_r[2]);

      sq_c_r[0] <= b5_c_r;
      for (int k = 1; k < SQ_N; k++) sq_c_r[k] <= sq_c_r[k-1];
      for (int k = 0; k < SQ_N; k++) begin
        sq_v_r[k] <= sq_v_nxt[k];
        sq_r_r[k] <= sq_r_nxt[k];
      end

      dv_c_r[0] <= sq_c_r[SQ_N-1];
      for (int j = 1; j < DV_N; j++) dv_c_r[j] <= dv_c_r[j-1];
      for (int j = 0; j < DV_N; j++) begin
        dv_n_r[j] <= dv_n_in[j];
        for (int a = 0; a < 3; a++) begin
          dv_rem_r[j][a] <= dv_rem_nxt[j][a];
          dv_q_r[j][a]   <= dv_q_nxt[j][a];
        end
      end

      p1_side_r <= dv_c_r[DV_N-1].side;
      for (int a = 0; a < 3; a++) p1_nrm_r[a] <= nrm_nxt[a];

      p2_side_r    <= p1_side_r;
      p2_prod_r[0] <= p1_nrm_r[0] * p1_side_r.vx1;
      p2_prod_r[1] <= p1_nrm_r[1] * p1_side_r.vy1;
      p2_prod_r[2] <= p1_nrm_r[2] * p1_side_r.vz1;
      for (int a = 0; a < 3; a++) p2_nrm_r[a] <= p1_nrm_r[a];

      p3_side_r <= p2_side_r;
      p3_sum_r  <= p2_prod_r[0] + p2_prod_r[1] + p2_prod_r[2];
      for (int a = 0; a < 3; a++) p3_nrm_r[a] <= p2_nrm_r[a];

      o_side_r  <= p3_side_r;
      o_plane_r <= dq_nxt;
      for (int a = 0; a < 3; a++) o_nrm_r[a] <= p3_nrm_r[a];
    end
  end

endmodule

/* rtl/triangle_setup_box_code_plane.sv */
// Triangle setup: bounding box codes, unit plane normal, plane offset and
// edge flags for one triangle per beat. Top level; depends on tsb_pkg,
// tsb_front, tsb_queue and tsb_back.
//
// One triangle is taken per clock and one result is given per clock for as
// long as results are popped. Most of the pipeline depth lies in the square
// root (one bit per stage, 32 stages) followed by the divider (one quotient
// bit per stage, 31 stages). The front stages stall only when the short
// queue before the back part is full, and the back part stalls only while
// its output register holds a result that is not popped. Configuration
// writes take effect on the next clock and should be done while no
// triangle is in flight.
module triangle_setup_box_code_plane #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_vx1,
  input  logic signed [31:0]  in_vy1,
  input  logic signed [31:0]  in_vz1,
  input  logic signed [31:0]  in_vx2,
  input  logic signed [31:0]  in_vy2,
  input  logic signed [31:0]  in_vz2,
  input  logic signed [31:0]  in_vx3,
  input  logic signed [31:0]  in_vy3,
  input  logic signed [31:0]  in_vz3,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_box_min_code,
  output logic [31:0]         out_box_max_code,
  output logic signed [31:0]  out_normal_a,
  output logic signed [31:0]  out_normal_b,
  output logic signed [31:0]  out_normal_c,
  output logic signed [47:0]  out_plane_offset,
  output logic                out_edge1_flat,
  output logic                out_edge2_flat,
  output logic                out_edge3_flat
);

  logic signed [31:0] vtx [9];
  logic               q_push, q_full, q_pop, q_empty;
  tsb_pkg::mid_t      q_wdata, q_rdata;

  assign vtx[0] = in_vx1;
  assign vtx[1] = in_vy1;
  assign vtx[2] = in_vz1;
  assign vtx[3] = in_vx2;
  assign vtx[4] = in_vy2;
  assign vtx[5] = in_vz2;
  assign vtx[6] = in_vx3;
  assign vtx[7] = in_vy3;
  assign vtx[8] = in_vz3;

  tsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .vtx       (vtx),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  tsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tsb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_rdata),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_box_min_code (out_box_min_code),
    .out_box_max_code (out_box_max_code),
    .out_normal_a     (out_normal_a),
    .out_normal_b     (out_normal_b),
    .out_normal_c     (out_normal_c),
    .out_plane_offset (out_plane_offset),
    .out_edge1_flat   (out_edge1_flat),
    .out_edge2_flat   (out_edge2_flat),
    .out_edge3_flat   (out_edge3_flat)
  );

endmodule

/* rtl/tsb_checker.sv */
// tsb_checker: port level checks for triangle_setup_box_code_plane, bound to
// the top level. Depends on the top level's ports only.
module tsb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input logic [31:0]         out_box_min_code,
  input logic [31:0]         out_box_max_code,
  input logic signed [31:0]  out_normal_a,
  input logic signed [31:0]  out_normal_b,
  input logic signed [31:0]  out_normal_c,
  input logic signed [47:0]  out_plane_offset
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queue not idle after reset");

  // a result that is not popped stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_box_min_code) &&
      $stable(out_box_max_code) && $stable(out_plane_offset))
    else $error("waiting result changed");

  // unit normal components stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_normal_a <= 32'sd1073741824 &&
      out_normal_a >= -32'sd1073741824 && out_normal_b <= 32'sd1073741824 &&
      out_normal_b >= -32'sd1073741824 && out_normal_c <= 32'sd1073741824 &&
      out_normal_c >= -32'sd1073741824)
    else $error("normal component out of range");

  // a zero normal only comes from a degenerate triangle, offset zero too
  a_degen_plane: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_normal_a == 0 && out_normal_b == 0 && out_normal_c == 0
      |-> out_plane_offset == 0)
    else $error("zero normal with nonzero plane offset");

endmodule

bind triangle_setup_box_code_plane tsb_checker u_tsb_checker (.*);

/* bench/tb_triangle_setup_box_code_plane.sv */
// Testbench for triangle_setup_box_code_plane: random and directed triangles
// against a bit-accurate plane and box-code predictor. Depends on tsb_pkg and
// the block's RTL.
module tb_triangle_setup_box_code_plane;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0, REG_OFFSET_Y = 3'd1, REG_OFFSET_Z = 3'd2,
    REG_SCALE_X = 3'd3, REG_SCALE_Y = 3'd4, REG_SCALE_Z = 3'd5,
    REG_UNUSED6 = 3'd6, REG_UNUSED7 = 3'd7
  } reg_idx_t;

  typedef logic signed [31:0] tri_t [9];

  typedef struct packed {
    logic [31:0]        min_code;
    logic [31:0]        max_code;
    logic signed [31:0] na;
    logic signed [31:0] nb;
    logic signed [31:0] nc;
    logic signed [47:0] offs;
    logic [2:0]         flat;
  } setup_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_vx1 = '0, in_vy1 = '0, in_vz1 = '0;
  logic signed [31:0] in_vx2 = '0, in_vy2 = '0, in_vz2 = '0;
  logic signed [31:0] in_vx3 = '0, in_vy3 = '0, in_vz3 = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [31:0] out_box_min_code, out_box_max_code;
  logic signed [31:0] out_normal_a, out_normal_b, out_normal_c;
  logic signed [47:0] out_plane_offset;
  logic out_edge1_flat, out_edge2_flat, out_edge3_flat;

  triangle_setup_box_code_plane dut (.*);

  always #5 clk = ~clk;

  // local copy of the configuration
  logic signed [31:0] off_x = '0, off_y = '0, off_z = '0;
  logic [31:0] scl_x = 32'd65536, scl_y = 32'd65536, scl_z = 32'd65536;

  tri_t triangles_pending [$];
  setup_res_t expected_setups [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  function automatic logic [10:0] quantize(logic signed [63:0] v, logic signed [31:0] off,
                                           logic [31:0] sc, logic [10:0] top);
    logic signed [63:0] s;
    logic [65:0] p;
    s = v + off;
    if (s <= 0) return 11'd0;
    p = s[32:0];
    p = (p * sc) >> 32;
    if (p > top) return top;
    return p[10:0];
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic setup_res_t plane_predict(tri_t t);
    logic signed [67:0] x [3], y [3], z [3];
    logic signed [67:0] dx [3], dy [3], dz [3];
    logic signed [67:0] w [3];
    logic [67:0] m [3];
    logic signed [63:0] r [3];
    logic [63:0] rm [3];
    logic signed [31:0] u [3];
    logic [63:0] ss, n, q;
    logic signed [63:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic signed [69:0] dsum;
    logic [69:0] dmag;
    logic [31:0] mn, mx;
    int len;
    setup_res_t res;
    for (int i = 0; i < 3; i++) begin
      x[i] = t[3*i];
      y[i] = t[3*i+1];
      z[i] = t[3*i+2];
    end
    lo_x = x[0]; hi_x = x[0]; lo_y = y[0]; hi_y = y[0]; lo_z = z[0]; hi_z = z[0];
    for (int i = 1; i < 3; i++) begin
      if (x[i] < lo_x) lo_x = x[i];
      if (x[i] > hi_x) hi_x = x[i];
      if (y[i] < lo_y) lo_y = y[i];
      if (y[i] > hi_y) hi_y = y[i];
      if (z[i] < lo_z) lo_z = z[i];
      if (z[i] > hi_z) hi_z = z[i];
    end
    mn = ({21'd0, quantize(lo_x, off_x, scl_x, tsb_pkg::XY_MAX)} << 21) |
         ({21'd0, quantize(lo_y, off_y, scl_y, tsb_pkg::XY_MAX)} << 10) |
         {21'd0, quantize(lo_z, off_z, scl_z, tsb_pkg::Z_MAX)};
    mx = ({21'd0, quantize(hi_x, off_x, scl_x, tsb_pkg::XY_MAX)} << 21) |
         ({21'd0, quantize(hi_y, off_y, scl_y, tsb_pkg::XY_MAX)} << 10) |
         {21'd0, quantize(hi_z, off_z, scl_z, tsb_pkg::Z_MAX)};
    for (int i = 0; i < 3; i++) begin
      dx[i] = x[(i+1)%3] - x[i];
      dy[i] = y[(i+1)%3] - y[i];
      dz[i] = z[(i+1)%3] - z[i];
    end
    w[0] = dy[0] * dz[1] - dy[1] * dz[0];
    w[1] = dz[0] * dx[1] - dz[1] * dx[0];
    w[2] = dx[0] * dy[1] - dx[1] * dy[0];
    len = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (w[i] < 0) ? -w[i] : w[i];
      for (int k = 0; k < 68; k++) if (m[i][k] && k + 1 > len) len = k + 1;
    end
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (len != 0) begin
      ss = 0;
      for (int i = 0; i < 3; i++) begin
        rm[i] = (len > tsb_pkg::UNIT_BITS) ? 64'(m[i] >> (len - tsb_pkg::UNIT_BITS))
                                           : 64'(m[i] << (tsb_pkg::UNIT_BITS - len));
        ss = ss + rm[i] * rm[i];
      end
      n = isqrt64(ss);
      if (n != 0) begin
        for (int i = 0; i < 3; i++) begin
          q = (rm[i] << tsb_pkg::UNIT_BITS) / n;
          u[i] = (w[i] < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
      end
    end
    dsum = 70'(u[0]) * 70'(x[0]) + 70'(u[1]) * 70'(y[0]) + 70'(u[2]) * 70'(z[0]);
    dmag = (dsum < 0) ? -dsum : dsum;
    dmag = dmag >> tsb_pkg::UNIT_BITS;
    res.min_code = mn - tsb_pkg::MIN_BIAS;
    res.max_code = mx;
    res.na = u[0];
    res.nb = u[1];
    res.nc = u[2];
    res.offs = (dsum < 0) ? -dmag[47:0] : dmag[47:0];
    for (int i = 0; i < 3; i++) begin
      res.flat[i] = ((dx[i] < 0) ? -dx[i] : dx[i]) > ((dy[i] < 0) ? -dy[i] : dy[i]);
    end
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h, predicted %h", $realtime, field, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    tri_t cur;
    if (rst_n) begin
      if (in_push && !in_full) begin
        cur = '{in_vx1, in_vy1, in_vz1, in_vx2, in_vy2, in_vz2, in_vx3, in_vy3, in_vz3};
        expected_setups.push_back(plane_predict(cur));
        void'(triangles_pending.pop_front());
      end
      if (triangles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = triangles_pending[0];
        in_push <= 1'b1;
        in_vx1 <= cur[0]; in_vy1 <= cur[1]; in_vz1 <= cur[2];
        in_vx2 <= cur[3]; in_vy2 <= cur[4]; in_vz2 <= cur[5];
        in_vx3 <= cur[6]; in_vy3 <= cur[7]; in_vz3 <= cur[8];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    setup_res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_setups.size() == 0) begin
          report("unexpected beat", out_box_min_code, 64'd0);
        end else begin
          want = expected_setups.pop_front();
          if (out_box_min_code !== want.min_code)
            report("box_min_code", out_box_min_code, want.min_code);
          if (out_box_max_code !== want.max_code)
            report("box_max_code", out_box_max_code, want.max_code);
          if (out_normal_a !== want.na) report("normal_a", out_normal_a, want.na);
          if (out_normal_b !== want.nb) report("normal_b", out_normal_b, want.nb);
          if (out_normal_c !== want.nc) report("normal_c", out_normal_c, want.nc);
          if (out_plane_offset !== want.offs)
            report("plane_offset", out_plane_offset, want.offs);
          if ({out_edge3_flat, out_edge2_flat, out_edge1_flat} !== want.flat)
            report("edge flags", {out_edge3_flat, out_edge2_flat, out_edge1_flat},
                   want.flat);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_setup_box_code_plane: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_OFFSET_X: off_x = val;
      REG_OFFSET_Y: off_y = val;
      REG_OFFSET_Z: off_z = val;
      REG_SCALE_X: scl_x = val;
      REG_SCALE_Y: scl_y = val;
      REG_SCALE_Z: scl_z = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] ox, oy, oz, sx, sy, sz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
  endtask

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    logic signed [31:0] base, d;
    int mode;
    int k;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      base = $signed($urandom_range(32'h1fffffff)) - 32'sh10000000;
      case (mode)
        0, 1: t[i] = $urandom;
        2: t[i] = pick_extreme();
        default: t[i] = base;
      endcase
    end
    // some collinear or repeated-vertex triangles
    if (mode == 8 || mode == 9) begin
      k = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        d = $signed($urandom_range(32'h3ffff)) - 32'sh20000;
        if (mode == 9) d = 0;
        t[3+i] = t[i] + d;
        t[6+i] = t[i] + k * d;
      end
    end
    return t;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (triangles_pending.size() != 0 || in_push || expected_setups.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_tri(logic signed [31:0] a, b, c, d, e, f, g, h, i);
    tri_t t;
    t = '{a, b, c, d, e, f, g, h, i};
    triangles_pending.push_back(t);
  endtask

  initial begin
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats at reset configuration
    @(negedge clk);
    add_tri(0, 0, 0, one, 0, 0, 0, one, 0);
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    add_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn);
    add_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn);
    add_tri(mn, mx, 0, mx, mn, 0, 0, 0, mx);
    add_tri(-one, -one, -one, -2 * one, one, 0, one, 2 * one, 3 * one);
    add_tri(0, 0, 0, one, one, 0, 2 * one, 2 * one, one);
    add_tri(one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, 3 * one, 6 * one, 9 * one);
    add_tri(32'sh07ff0000, 32'sh07ff0000, 32'sh03ff0000,
            32'sh08000000, 32'sh08000000, 32'sh04000000, 0, 5, 7);
    add_tri(32'sh12345678, -5, 99, -32'sh1234, 32'sh7000, 8, 3, 3, 3);
    add_tri(1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(one, 0, 0, 0, one, 0, 0, 0, one);
    add_tri(-3, 7, mx, 9, -1, mn, 4, 4, 0);
    wait_idle();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin
          write_all(0, 0, 0, 32'd65536, 32'd65536, 32'd65536);
          write_reg(REG_UNUSED7, 32'hdeadbeef);
          write_reg(REG_UNUSED6, 32'h12345678);
        end
        1: write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'hffffffff, 32'hffffffff, 32'hffffffff);
        2: write_all(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        3: write_all(32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 1, 32'd65536);
        4, 5: write_all($signed($urandom_range(32'h0fffffff)) - 32'sh08000000,
                        $signed($urandom_range(32'h0fffffff)) - 32'sh08000000,
                        $signed($urandom_range(32'h0fffffff)) - 32'sh08000000,
                        $urandom_range(32'h40000, 32'h400),
                        $urandom_range(32'h40000, 32'h400),
                        $urandom_range(32'h40000, 32'h400));
        default: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 70; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      @(negedge clk);
      for (int i = 0; i < 70; i++) triangles_pending.push_back(random_triangle());
      // hold off the sender until the pipe has fully drained
      @(negedge clk);
      while (triangles_pending.size() != 0 || in_push || expected_setups.size() != 0)
        @(negedge clk);
      for (int i = 0; i < 67; i++) triangles_pending.push_back(random_triangle());
      wait_idle();
    end

    if (errors == 0) begin
      $display("triangle_setup_box_code_plane: match");
    end else begin
      $display("triangle_setup_box_code_plane: mismatch");
    end
    $finish;
  end

endmodule
